// ===== rtl/core/lrup_pkg.sv =====
// ----------------------------------------------------------------------------
// lrup_pkg
// Shared types and constants for the LRU page replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package lrup_pkg;

    localparam int PAGE_W  = 16;
    localparam int LIMIT_W = 4;
    localparam int COUNT_W = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 32'hFFFF_FFFF;

    typedef logic [PAGE_W-1:0]  t_page;
    typedef logic [LIMIT_W-1:0] t_limit;
    typedef logic [COUNT_W-1:0] t_count;

    // link handed from one cell to the next one down the recency stack
    typedef struct packed {
        t_page  page;     // page held by the cell above
        logic   valid;    // cell above holds a resident page
        logic   last;     // cell above is the least recent resident page
        logic   found;    // lookup page matched at or above this point
        t_page  ev_page;  // page of the least recent cell at or above
    } t_link;

endpackage

`default_nettype wire

// ===== rtl/core/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU page tracker built as a recency stack of cells.
// ----------------------------------------------------------------------------
// Usage:
//   A page reference is taken at a rising edge with i_start high and o_busy
//   low. The word is registered, and in the next cycle the stack of cells
//   compares it against every resident page and shifts: cell 0 holds the
//   most recent page, the last valid cell the least recent one.
//   At the edge that ends that pass, o_done is raised for exactly one cycle with
//   o_fault, o_evicted_valid, o_victim_page and o_fault_total. The receiver
//   cannot stall; each word is shown once.
//   o_busy stays high during the compare-and-shift pass of the chain, so no new
//   reference is taken until that pass is done.
//   The frame limit is written through i_cfg_wr_en / i_cfg_wr_data while
//   idle; values above NUM_FRAMES act as NUM_FRAMES, zero faults always.
//   Reset clears every cell, the fault count and sets the limit to 8.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement #(
    parameter int NUM_FRAMES = 8
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire lrup_pkg::t_page  i_page_number,
    input  wire                  i_cfg_wr_en,
    input  wire lrup_pkg::t_limit i_cfg_wr_data,
    output logic                 o_busy,
    output logic                 o_done,
    output logic                 o_fault,
    output logic                 o_evicted_valid,
    output lrup_pkg::t_page      o_victim_page,
    output lrup_pkg::t_count     o_fault_total
);
    import lrup_pkg::*;

    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

    t_limit r_limit;
    logic   r_go;
    t_page  r_page;
    t_count r_count;
    t_count n_count;

    logic [LW-1:0]         lim_ext;
    logic [LW-1:0]         lim_eff;
    logic                  lim_zero;
    logic                  en;
    logic                  full;
    logic                  hit;
    logic                  fault;
    logic                  evict;
    logic [NUM_FRAMES-1:0] full_vec;
    t_link                 links [0:NUM_FRAMES];

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= 1'b0;
        end else begin
            r_go <= i_start && !r_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_go) begin
            r_page <= i_page_number;
        end
    end

    assign o_busy = r_go;

    // effective limit, clamped to the number of cells
    assign lim_ext  = LW'(r_limit);
    assign lim_eff  = (lim_ext > LW'(NUM_FRAMES)) ? LW'(NUM_FRAMES) : lim_ext;
    assign lim_zero = (lim_eff == '0);
    assign en       = r_go && !lim_zero;

    // stack is full when the cell at the limit boundary is occupied
    always_comb begin
        for (int i = 0; i < NUM_FRAMES; i++) begin
            full_vec[i] = links[i+1].valid && (lim_eff == LW'(i + 1));
        end
    end
    assign full = |full_vec;

    // head of the chain: the referenced page enters as most recent
    always_comb begin
        links[0].page    = r_page;
        links[0].valid   = 1'b1;
        links[0].last    = 1'b0;
        links[0].found   = 1'b0;
        links[0].ev_page = '0;
    end

    // recency stack
    for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
        logic next_valid;
        if (g == NUM_FRAMES - 1) begin : g_tail
            assign next_valid = 1'b0;
        end else begin : g_body
            assign next_valid = links[g+2].valid;
        end
        lrup_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (en),
            .i_page       (r_page),
            .i_full       (full),
            .i_next_valid (next_valid),
            .i_link       (links[g]),
            .o_link       (links[g+1])
        );
    end

    // result decode
    assign hit   = !lim_zero && links[NUM_FRAMES].found;
    assign fault = !hit;
    assign evict = !lim_zero && fault && full;

    // saturating fault count
    always_comb begin
        n_count = r_count;
        if (r_go && fault && (r_count != COUNT_MAX)) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_go) begin
            o_fault         <= fault;
            o_evicted_valid <= evict;
            o_victim_page   <= evict ? links[NUM_FRAMES].ev_page : '0;
            o_fault_total   <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lrup_cell.sv =====
// ----------------------------------------------------------------------------
// lrup_cell
// One slot of the recency stack: holds a page, compares it with the lookup
// page and takes the content of the slot above when the stack shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module lrup_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire lrup_pkg::t_page i_page,
    input  wire                 i_full,
    input  wire                 i_next_valid,
    input  wire lrup_pkg::t_link i_link,
    output lrup_pkg::t_link     o_link
);
    import lrup_pkg::*;

    t_page r_page;
    logic  r_valid;
    t_page n_page;
    logic  n_valid;
    logic  match;
    logic  last;

    // lookup compare and end-of-stack detect
    assign match = r_valid && (r_page == i_page);
    assign last  = r_valid && !i_next_valid;

    // link to the cell below
    always_comb begin
        o_link.page    = r_page;
        o_link.valid   = r_valid;
        o_link.last    = last;
        o_link.found   = i_link.found || match;
        o_link.ev_page = i_link.ev_page | (last ? r_page : '0);
    end

    // shift from above unless the hit lies above this cell
    always_comb begin
        n_page  = r_page;
        n_valid = r_valid;
        if (i_en && !i_link.found) begin
            n_page  = i_link.page;
            n_valid = i_link.valid && !(i_link.last && i_full);
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lrup_chk.sv =====
// ----------------------------------------------------------------------------
// lrup_chk
// Port-level checks for the LRU page replacement block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module lrup_chk (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_start,
    input wire                  o_busy,
    input wire                  o_done,
    input wire                  o_fault,
    input wire                  o_evicted_valid,
    input wire lrup_pkg::t_page  o_victim_page,
    input wire lrup_pkg::t_count o_fault_total
);
    import lrup_pkg::*;

    // an accepted word makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("busy not raised after accept");

    // every busy cycle ends in a result word
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy |=> (o_done && !o_busy))
        else $error("no result word after busy");

    // an eviction only happens on a fault
    a_evict_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_evicted_valid) |-> o_fault)
        else $error("eviction without fault");

    // no eviction reports page zero
    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_evicted_valid) |-> (o_victim_page == '0))
        else $error("evicted page not zero");

    // a fault leaves a nonzero total
    a_fault_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_fault) |-> (o_fault_total != '0))
        else $error("fault total zero on fault");

endmodule

bind lru_page_replacement lrup_chk u_lrup_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (i_start),
    .o_busy          (o_busy),
    .o_done          (o_done),
    .o_fault         (o_fault),
    .o_evicted_valid (o_evicted_valid),
    .o_victim_page   (o_victim_page),
    .o_fault_total   (o_fault_total)
);

`default_nettype wire
